// ===== rtl/lzfgd_pkg.sv =====
`timescale 1ns / 1ps

package lzfgd_pkg;

	localparam int WIN_DEPTH  = 1023;
	localparam int WIN_AW     = 10;
	localparam int COPY_DEPTH = 63;
	localparam int COPY_AW    = 6;

	localparam logic [7:0] FILL_RESET = 8'h20;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_LIT  = 2'd1;
	localparam logic [1:0] ACT_COPY = 2'd2;

	localparam logic [1:0] PH_HEAD   = 2'd0;
	localparam logic [1:0] PH_TOKEN  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	localparam logic [2:0] FLAGS_DONE = 3'd7;

	typedef struct packed {
		logic accept;
		logic lit_out;
		logic rd_issue;
		logic emit;
		logic wb_rd;
		logic wb_wr;
	} lzfgd_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       len_zero;
		logic       out_free;
		logic       idx_last;
	} lzfgd_sts_t;

endpackage

// ===== rtl/lzfgd_if.sv =====
`timescale 1ns / 1ps

interface lzfgd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       new_stream;

	modport source (output valid, output in_byte, output new_stream, input ready);
	modport sink (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzfgd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/lzfgd_ram.sv =====
`timescale 1ns / 1ps

module lzfgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lzfgd_ctrl.sv =====
`timescale 1ns / 1ps

module lzfgd_ctrl
	import lzfgd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  lzfgd_sts_t sts,
	output lzfgd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LIT   = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_WB_RD = 3'd4;
	localparam logic [2:0] ST_WB_WR = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (sts.action)
						ACT_LIT:  state_d = ST_LIT;
						ACT_COPY: state_d = sts.len_zero ? ST_IDLE : ST_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LIT: begin
				if (sts.out_free) begin
					cmd.lit_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.idx_last ? ST_WB_RD : ST_RD;
				end
			end
			ST_WB_RD: begin
				cmd.wb_rd = 1'b1;
				state_d   = ST_WB_WR;
			end
			ST_WB_WR: begin
				cmd.wb_wr = 1'b1;
				state_d   = sts.idx_last ? ST_IDLE : ST_WB_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/lzfgd_dp.sv =====
`timescale 1ns / 1ps

module lzfgd_dp
	import lzfgd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lzfgd_cmd_t cmd,
	output lzfgd_sts_t sts,
	input  logic [7:0] in_byte,
	input  logic       new_stream,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [7:0]         fill_cfg_q;
	logic [7:0]         win_fill_q;
	logic [1:0]         phase_q;
	logic [7:0]         flag_q;
	logic [2:0]         used_q;
	logic [7:0]         held_q;
	logic [WIN_AW-1:0]  wp_q;
	logic [WIN_AW-1:0]  cnt_q;
	logic [WIN_AW-1:0]  src_q;
	logic [COPY_AW-1:0] len_q;
	logic [COPY_AW-1:0] idx_q;
	logic [7:0]         byte_q;
	logic               rd_hit_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic [1:0]         ph;
	logic [7:0]         fb;
	logic [7:0]         fbs;
	logic [2:0]         fu;
	logic               is_token;
	logic               tok_flag;
	logic [1:0]         action;
	logic [1:0]         phase_d;
	logic [7:0]         flag_d;
	logic [2:0]         used_d;
	logic [7:0]         held_d;
	logic [WIN_AW:0]    src_sum;
	logic [WIN_AW-1:0]  src_start;
	logic [WIN_AW-1:0]  src_next;
	logic [WIN_AW-1:0]  wp_next;
	logic [7:0]         win_rdata;
	logic [7:0]         cb_rdata;
	logic [7:0]         emit_val;
	logic               win_we;
	logic [7:0]         win_wdata;

	always_comb begin
		ph       = new_stream ? PH_HEAD : phase_q;
		fb       = new_stream ? 8'd0 : flag_q;
		fu       = new_stream ? FLAGS_DONE : used_q;
		fbs      = {fb[6:0], 1'b0};
		held_d   = new_stream ? 8'd0 : held_q;
		action   = ACT_NONE;
		phase_d  = ph;
		flag_d   = fb;
		used_d   = fu;
		is_token = 1'b0;
		tok_flag = 1'b0;
		case (ph)
			PH_SECOND: begin
				action  = ACT_COPY;
				phase_d = PH_HEAD;
			end
			PH_TOKEN: begin
				is_token = 1'b1;
				tok_flag = fb[7];
			end
			default: begin
				flag_d = fbs;
				if (fu == FLAGS_DONE) begin
					flag_d  = in_byte;
					used_d  = 3'd0;
					phase_d = PH_TOKEN;
				end else begin
					used_d   = fu + 3'd1;
					is_token = 1'b1;
					tok_flag = fbs[7];
				end
			end
		endcase
		if (is_token) begin
			if (!tok_flag) begin
				action  = ACT_LIT;
				phase_d = PH_HEAD;
			end else begin
				held_d  = in_byte;
				phase_d = PH_SECOND;
			end
		end
	end

	assign src_sum   = {1'b0, wp_q} + (WIN_AW+1)'(WIN_DEPTH) - {1'b0, held_q[1:0], in_byte};
	assign src_start = (src_sum >= (WIN_AW+1)'(WIN_DEPTH)) ?
		WIN_AW'(src_sum - (WIN_AW+1)'(WIN_DEPTH)) : src_sum[WIN_AW-1:0];
	assign src_next  = (src_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : src_q + 1'b1;
	assign wp_next   = (wp_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign emit_val  = rd_hit_q ? win_rdata : win_fill_q;

	assign sts.action   = action;
	assign sts.len_zero = (held_q[7:2] == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.idx_last = ((idx_q + 1'b1) == len_q);

	assign win_we    = cmd.lit_out || cmd.wb_wr;
	assign win_wdata = cmd.lit_out ? byte_q : cb_rdata;

	lzfgd_ram #(
		.WIDTH (8),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (win_we),
		.waddr (wp_q),
		.wdata (win_wdata),
		.re    (cmd.rd_issue),
		.raddr (src_q),
		.rdata (win_rdata)
	);

	lzfgd_ram #(
		.WIDTH (8),
		.DEPTH (COPY_DEPTH)
	) u_copy_buf (
		.clk   (clk),
		.we    (cmd.emit),
		.waddr (idx_q),
		.wdata (emit_val),
		.re    (cmd.wb_rd),
		.raddr (idx_q),
		.rdata (cb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cfg_q  <= FILL_RESET;
			win_fill_q  <= FILL_RESET;
			phase_q     <= PH_HEAD;
			flag_q      <= '0;
			used_q      <= FLAGS_DONE;
			held_q      <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			src_q       <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			rd_hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fill_cfg_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				phase_q <= phase_d;
				flag_q  <= flag_d;
				used_q  <= used_d;
				held_q  <= held_d;
				if (new_stream) begin
					wp_q       <= '0;
					cnt_q      <= '0;
					win_fill_q <= fill_cfg_q;
				end
				if (action == ACT_COPY) begin
					src_q <= src_start;
					len_q <= held_q[7:2];
					idx_q <= '0;
				end
			end
			if (win_we) begin
				wp_q <= wp_next;
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.rd_issue) begin
				rd_hit_q <= (src_q < cnt_q);
			end
			if (cmd.emit) begin
				src_q <= src_next;
				idx_q <= sts.idx_last ? '0 : idx_q + 1'b1;
			end
			if (cmd.wb_wr) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.lit_out || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_byte;
		end
		if (cmd.lit_out) begin
			out_byte_q <= byte_q;
			out_last_q <= 1'b1;
		end else if (cmd.emit) begin
			out_byte_q <= emit_val;
			out_last_q <= sts.idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/lzfgd_top.sv =====
`timescale 1ns / 1ps

// LZSS decoder, flag-grouped tokens, 10-bit offset, 6-bit length.
// comp: compressed bytes, one per beat, with new_stream to restart the window.
// decomp: decompressed bytes, one per beat, last marks the final beat of an item.
// cfg_we/cfg_wdata: window fill byte, taken on any edge with cfg_we high.
// An item is taken only while the sequencer is idle. A flag byte or the first
// byte of a copy token is only taken; a literal is taken, then loads the output
// register and the window. A copy token of length L is taken, then for each
// byte runs a window read, then an output load, and a second pass moves the
// copy buffer back into the window, one port each way.
// Output valid, byte and last are driven straight from registers.
// A stalled receiver holds the output register; the sequencer waits on it
// before each load, so the next item is taken while the last beat still waits.
// Reset clears the parse state, write pointer and fill count and sets the fill
// byte to 0x20. Window entries not yet written in a stream read as the fill
// byte latched at stream start, so no clearing pass runs after reset.
module lzss_flag_grouped_decoder
	import lzfgd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	lzfgd_in_if.sink      comp,
	lzfgd_out_if.source   decomp
);

	lzfgd_cmd_t cmd;
	lzfgd_sts_t sts;

	lzfgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp.valid),
		.in_ready (comp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzfgd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (comp.in_byte),
		.new_stream (comp.new_stream),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (decomp.valid),
		.out_ready  (decomp.ready),
		.out_byte   (decomp.out_byte),
		.out_last   (decomp.last)
	);

endmodule

// ===== sim/lzfgd_checker.sv =====
`timescale 1ns / 1ps

module lzfgd_checker
	import lzfgd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       new_stream,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       last,
	output int         pending,
	output int         errors
);

	typedef struct {
		logic [7:0] data;
		logic       is_last;
	} plain_beat_t;

	plain_beat_t plain_q [$];
	logic [7:0]  win [0:WIN_DEPTH-1];
	logic [7:0]  fill_value;
	int          wpos;
	logic [7:0]  flags;
	logic [2:0]  used;
	logic [1:0]  phase;
	logic [7:0]  held;
	int          beat_no;

	task automatic log_error(input string msg);
		if (errors < 50)
			$display("%0t lzfgd_checker: %s", $realtime, msg);
		errors++;
	endtask

	task automatic restart_stream();
		int i;
		for (i = 0; i < WIN_DEPTH; i++)
			win[i] = fill_value;
		wpos  = 0;
		flags = 8'h00;
		used  = FLAGS_DONE;
		phase = PH_HEAD;
		held  = 8'h00;
	endtask

	task automatic push_plain(input logic [7:0] data, input logic is_last);
		plain_beat_t beat;
		beat.data    = data;
		beat.is_last = is_last;
		plain_q.push_back(beat);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic restart);
		logic [5:0] len;
		logic [9:0] ofs;
		logic [7:0] grabbed [0:COPY_DEPTH-1];
		int         src;
		int         i;
		if (restart)
			restart_stream();
		if (phase == PH_SECOND) begin
			phase = PH_HEAD;
			len   = held[7:2];
			ofs   = {held[1:0], b};
			src   = (wpos + WIN_DEPTH - int'(ofs)) % WIN_DEPTH;
			for (i = 0; i < int'(len); i++) begin
				grabbed[i] = win[(src + i) % WIN_DEPTH];
				push_plain(grabbed[i], i + 1 == int'(len));
			end
			for (i = 0; i < int'(len); i++)
				win[(wpos + i) % WIN_DEPTH] = grabbed[i];
			wpos = (wpos + int'(len)) % WIN_DEPTH;
			return;
		end
		if (phase != PH_TOKEN) begin
			flags = flags << 1;
			if (used == FLAGS_DONE) begin
				flags = b;
				used  = 3'd0;
				phase = PH_TOKEN;
				return;
			end
			used = used + 3'd1;
		end
		if (!flags[7]) begin
			phase     = PH_HEAD;
			win[wpos] = b;
			wpos      = (wpos + 1) % WIN_DEPTH;
			push_plain(b, 1'b1);
		end else begin
			held  = b;
			phase = PH_SECOND;
		end
	endtask

	task automatic check_beat();
		plain_beat_t want;
		if (plain_q.size() == 0) begin
			log_error($sformatf("unexpected beat %0d: byte %02h last %0b",
				beat_no, out_byte, last));
		end else begin
			want = plain_q.pop_front();
			if (out_byte !== want.data)
				log_error($sformatf("beat %0d: out_byte %02h, want %02h",
					beat_no, out_byte, want.data));
			if (last !== want.is_last)
				log_error($sformatf("beat %0d: last %0b, want %0b",
					beat_no, last, want.is_last));
		end
		beat_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_value = FILL_RESET;
			restart_stream();
			plain_q.delete();
			beat_no = 0;
			errors  = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (cfg_we)
				fill_value = cfg_wdata;
			if (in_valid && in_ready)
				decode_byte(in_byte, new_stream);
			pending <= plain_q.size();
		end
	end

endmodule

// ===== sim/lzss_flag_grouped_decoder_tb.sv =====
`timescale 1ns / 1ps

module lzss_flag_grouped_decoder_tb;

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         pending;
	int         errors;
	int         sent;
	bit         hold_req;
	bit         calm;

	lzfgd_in_if  comp ();
	lzfgd_out_if decomp ();

	lzss_flag_grouped_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.comp      (comp),
		.decomp    (decomp)
	);

	lzfgd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (comp.valid),
		.in_ready   (comp.ready),
		.in_byte    (comp.in_byte),
		.new_stream (comp.new_stream),
		.out_valid  (decomp.valid),
		.out_ready  (decomp.ready),
		.out_byte   (decomp.out_byte),
		.last       (decomp.last),
		.pending    (pending),
		.errors     (errors)
	);

	always #5 clk = ~clk;

	// {new_stream, byte}: literals, zero-length copy, longest copy at x = 0,
	// x = 1023, overlapping copy, truncated token, restart over a held token
	logic [8:0] opening [0:20] = '{
		9'h155, 9'h000, 9'h003, 9'h0FF, 9'h0FF, 9'h0FC, 9'h000, 9'h0A5,
		9'h00B, 9'h0FF, 9'h05A, 9'h00C, 9'h002, 9'h080, 9'h0FF, 9'h1FF,
		9'h007, 9'h140, 9'h07E, 9'h007, 9'h000
	};

	task automatic send_byte(input logic [7:0] b, input logic restart);
		comp.valid      <= 1'b1;
		comp.in_byte    <= b;
		comp.new_stream <= restart;
		@(posedge clk);
		while (!comp.ready)
			@(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			comp.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_stream(input int n_tokens);
		logic [7:0] flag;
		logic [5:0] len;
		logic [9:0] ofs;
		int         t;
		int         k;
		bit         opened;
		t      = 0;
		opened = 1'b0;
		while (t < n_tokens) begin
			flag = 8'($urandom);
			send_byte(flag, !opened);
			opened = 1'b1;
			for (k = 7; k >= 0 && t < n_tokens; k--) begin
				if (!flag[k]) begin
					send_byte(8'($urandom), 1'b0);
				end else begin
					len  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
						: 6'($urandom_range(0, 6));
					ofs  = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(1, 24));
					send_byte({len, ofs[9:8]}, 1'b0);
					// cut the stream short mid-token now and then
					if (t + 1 < n_tokens || $urandom_range(0, 3) != 0)
						send_byte(ofs[7:0], 1'b0);
				end
				t++;
			end
		end
	endtask

	task automatic drain();
		comp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fill(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		decomp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				decomp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				decomp.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				decomp.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int i;
		hold_req = 1'b0;
		calm     = 1'b0;
		sent     = 0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= 8'h00;
		comp.valid      <= 1'b0;
		comp.in_byte    <= 8'h00;
		comp.new_stream <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 21; i++)
			send_byte(opening[i][7:0], opening[i][8]);
		drain();

		write_fill(8'h00);
		while (sent < 100)
			send_stream($urandom_range(1, 20));
		drain();

		write_fill(8'hFF);
		hold_req = 1'b1;
		while (sent < 170)
			send_stream($urandom_range(1, 20));
		drain();

		write_fill(8'($urandom_range(1, 254)));
		repeat (30)
			send_byte(8'($urandom), $urandom_range(0, 7) == 0);
		while (sent < 235)
			send_stream($urandom_range(1, 20));
		calm = 1'b1;
		while (sent < 272)
			send_stream($urandom_range(1, 20));
		drain();

		if (errors == 0)
			$display("lzss_flag_grouped_decoder_tb: PASS");
		else
			$display("lzss_flag_grouped_decoder_tb: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("lzss_flag_grouped_decoder_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lzfgd_pkg.sv
rtl/lzfgd_if.sv
rtl/lzfgd_ram.sv
rtl/lzfgd_ctrl.sv
rtl/lzfgd_dp.sv
rtl/lzfgd_top.sv
sim/lzfgd_checker.sv
sim/lzss_flag_grouped_decoder_tb.sv
